// ===== design/bpc_pkg.sv =====
// bpc_pkg: types, register indexes and constants shared by the
// barometric pressure compensation block; no dependencies
`timescale 1ns / 1ps

package bpc_pkg;

   // divider geometry: 32-bit dividend, 18-bit divisor, one quotient bit per stage
   localparam int DVD_W = 32;
   localparam int DVS_W = 18;

   // configuration port
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PAIR_A = 3'd0,
      CSR_PAIR_B = 3'd1,
      CSR_PAIR_C = 3'd2,
      CSR_PAIR_D = 3'd3,
      CSR_PAIR_E = 3'd4,
      CSR_OSS    = 3'd5
   } csr_index_type;

   // calibration reset values
   localparam logic [31:0] PAIR_A_RESET = 32'd26804152;
   localparam logic [31:0] PAIR_B_RESET = 32'd3352395749;
   localparam logic [31:0] PAIR_C_RESET = 32'd2146785905;
   localparam logic [31:0] PAIR_D_RESET = 32'd405667844;
   localparam logic [31:0] PAIR_E_RESET = 32'd3724086068;
   localparam logic [1:0]  OSS_RESET    = 2'd0;

   // compensation constants
   localparam logic signed [28:0] B6_OFFSET   = 29'sd4000;
   localparam logic [31:0]        B4_BIAS     = 32'd32768;
   localparam logic [15:0]        PRESS_SCALE = 16'd50000;
   localparam logic [11:0]        P_QUAD      = 12'd3038;
   localparam logic signed [13:0] P_LIN       = -14'sd7357;
   localparam logic signed [47:0] P_BIAS      = 48'sd3791;
   localparam logic signed [15:0] T_MAX       = 16'sh7fff;
   localparam logic signed [15:0] T_MIN       = 16'sh8000;
   localparam logic [19:0]        P_MAX       = 20'hfffff;

   // channel payloads
   typedef struct packed {
      logic [15:0] raw_temp;
      logic [18:0] raw_pressure;
   } req_type;

   typedef struct packed {
      logic signed [15:0] temp_tenths;
      logic [19:0]        pressure_pa;
      logic               div_error;
   } rsp_type;

   // decoded calibration
   typedef struct packed {
      logic signed [15:0] ac1;
      logic signed [15:0] ac2;
      logic signed [15:0] ac3;
      logic [15:0]        ac4;
      logic [15:0]        ac5;
      logic [15:0]        ac6;
      logic signed [15:0] b1;
      logic signed [15:0] b2;
      logic signed [15:0] mc;
      logic signed [15:0] md;
      logic [1:0]         oss;
   } cal_type;

   // sideband through the temperature divider
   typedef struct packed {
      logic signed [18:0] x1;
      logic               neg;
      logic               err;
      logic [18:0]        up;
   } ttag_type;

   localparam int TAG_W = $bits(ttag_type);

   // sideband through the pressure divider
   typedef struct packed {
      logic signed [15:0] t;
      logic               err;
      logic               big;
      logic [TAG_W-19:0]  spare;
   } ptag_type;

   // divider transaction; on the output side num carries the quotient
   typedef struct packed {
      logic             vld;
      logic [DVD_W-1:0] num;
      logic [DVS_W-1:0] den;
      logic [TAG_W-1:0] tag;
   } div_type;

endpackage

// ===== design/bpc_div.sv =====
// bpc_div: pipelined restoring divider, one quotient bit per stage,
// sideband tag travels with each transaction; uses bpc_pkg
`timescale 1ns / 1ps

module bpc_div (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  bpc_pkg::div_type din,
   output bpc_pkg::div_type dout
);
   import bpc_pkg::*;

   logic             vld_ff [DVD_W];
   logic [DVS_W-1:0] rem_ff [DVD_W];
   logic [DVD_W-1:0] acc_ff [DVD_W];
   logic [DVS_W-1:0] den_ff [DVD_W];
   logic [TAG_W-1:0] tag_ff [DVD_W];
   logic [DVS_W-1:0] rem_in [DVD_W];
   logic [DVD_W-1:0] acc_in [DVD_W];

   // one shift, compare and subtract step
   function automatic logic [DVS_W+DVD_W-1:0] div_step(
      input logic [DVS_W-1:0] rem,
      input logic [DVD_W-1:0] acc,
      input logic [DVS_W-1:0] den
   );
      logic [DVS_W:0] trial;
      logic [DVS_W:0] diff;
      trial = {rem, acc[DVD_W-1]};
      diff  = trial - {1'b0, den};
      if (trial >= {1'b0, den}) begin
         div_step = {diff[DVS_W-1:0], acc[DVD_W-2:0], 1'b1};
      end else begin
         div_step = {trial[DVS_W-1:0], acc[DVD_W-2:0], 1'b0};
      end
   endfunction

   // next value of every stage
   always_comb begin
      {rem_in[0], acc_in[0]} = div_step('0, din.num, din.den);
      for (int k = 1; k < DVD_W; k++) begin
         {rem_in[k], acc_in[k]} = div_step(rem_ff[k-1], acc_ff[k-1], den_ff[k-1]);
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DVD_W; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= din.vld;
         for (int k = 1; k < DVD_W; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= rem_in[0];
         acc_ff[0] <= acc_in[0];
         den_ff[0] <= din.den;
         tag_ff[0] <= din.tag;
         for (int k = 1; k < DVD_W; k++) begin
            rem_ff[k] <= rem_in[k];
            acc_ff[k] <= acc_in[k];
            den_ff[k] <= den_ff[k-1];
            tag_ff[k] <= tag_ff[k-1];
         end
      end
   end

   assign dout.vld = vld_ff[DVD_W-1];
   assign dout.num = acc_ff[DVD_W-1];
   assign dout.den = den_ff[DVD_W-1];
   assign dout.tag = tag_ff[DVD_W-1];

endmodule

// ===== design/bpc_front.sv =====
// bpc_front: temperature front end, raw temperature to the operands of
// the temperature division; uses bpc_pkg
`timescale 1ns / 1ps

module bpc_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             req_vld,
   input  bpc_pkg::req_type req,
   input  bpc_pkg::cal_type cal,
   output bpc_pkg::div_type dout
);
   import bpc_pkg::*;

   logic               f1_vld_ff, f2_vld_ff, f3_vld_ff, f4_vld_ff;
   logic signed [16:0] f1_d_ff;
   logic [18:0]        f1_up_ff, f2_up_ff, f3_up_ff;
   logic signed [33:0] f2_prod_ff;
   logic signed [18:0] f3_x1_ff;
   logic signed [19:0] f3_den_ff;
   div_type            f4_ff;

   logic signed [18:0] x1_c;
   logic signed [19:0] den_c;
   logic signed [26:0] num_c;
   logic [26:0]        num_mag;
   logic [19:0]        den_mag;
   ttag_type           tag_c;
   div_type            f4_in;

   // x1 and denominator
   always_comb begin
      x1_c  = 19'(f2_prod_ff >>> 15);
      den_c = 20'(x1_c) + 20'(cal.md);
   end

   // sign and magnitude of the division operands
   always_comb begin
      num_c   = {cal.mc, 11'b0};
      num_mag = num_c[26] ? 27'(-num_c) : 27'(num_c);
      den_mag = f3_den_ff[19] ? 20'(-f3_den_ff) : 20'(f3_den_ff);
      tag_c.x1  = f3_x1_ff;
      tag_c.neg = num_c[26] ^ f3_den_ff[19];
      tag_c.err = (f3_den_ff == '0);
      tag_c.up  = f3_up_ff;
      f4_in.vld = f3_vld_ff;
      f4_in.num = DVD_W'(num_mag);
      f4_in.den = den_mag[DVS_W-1:0];
      f4_in.tag = tag_c;
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
         f3_vld_ff <= 1'b0;
         f4_vld_ff <= 1'b0;
      end else if (en) begin
         f1_vld_ff <= req_vld;
         f2_vld_ff <= f1_vld_ff;
         f3_vld_ff <= f2_vld_ff;
         f4_vld_ff <= f3_vld_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (en) begin
         f1_d_ff    <= $signed({1'b0, req.raw_temp}) - $signed({1'b0, cal.ac6});
         f1_up_ff   <= req.raw_pressure;
         f2_prod_ff <= f1_d_ff * $signed({1'b0, cal.ac5});
         f2_up_ff   <= f1_up_ff;
         f3_x1_ff   <= x1_c;
         f3_den_ff  <= den_c;
         f3_up_ff   <= f2_up_ff;
         f4_ff      <= f4_in;
      end
   end

   always_comb begin
      dout     = f4_ff;
      dout.vld = f4_vld_ff;
   end

endmodule

// ===== design/bpc_mid.sv =====
// bpc_mid: temperature result and pressure coefficients b3, b4, b7,
// feeding the pressure division; uses bpc_pkg
`timescale 1ns / 1ps

module bpc_mid (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  bpc_pkg::div_type din,
   input  bpc_pkg::cal_type cal,
   output bpc_pkg::div_type dout
);
   import bpc_pkg::*;

   logic               vld_ff [9];
   logic               err_ff [9];
   logic signed [15:0] t_ff [2:9];
   logic [18:0]        up_ff [1:7];

   logic signed [28:0] m1_b5_ff;
   logic signed [28:0] m2_b6_ff;
   logic signed [57:0] m3_sq_ff;
   logic signed [44:0] m3_a2_ff, m3_a3_ff;
   logic signed [45:0] m4_sq_ff;
   logic signed [33:0] m4_x2_ff, m5_x2_ff;
   logic signed [31:0] m4_x1_ff, m5_x1_ff;
   logic signed [61:0] m5_b2_ff, m5_b1_ff;
   logic signed [51:0] m6_x3_ff;
   logic signed [46:0] m6_x3b_ff;
   logic [31:0]        m7_b3_ff, m7_x3p_ff;
   logic [31:0]        m8_b7a_ff, m8_b4p_ff;
   logic [31:0]        m9_b7_ff;
   logic [16:0]        m9_b4_ff;

   ttag_type           ttag;
   logic signed [27:0] qs, x2_c;
   logic signed [28:0] b5_c;
   logic signed [29:0] tsum;
   logic signed [25:0] tsh;
   logic signed [15:0] t_c;
   logic signed [50:0] x1b_c;
   logic signed [45:0] x2b_c;
   logic [33:0]        v_c;
   logic [47:0]        b4w_c;
   logic [47:0]        b7w_c;
   logic [15:0]        scale_c;
   ptag_type           ptag;

   // signed quotient and b5
   always_comb begin
      ttag = ttag_type'(din.tag);
      qs   = $signed({1'b0, din.num[26:0]});
      x2_c = ttag.neg ? -qs : qs;
      b5_c = ttag.x1 + x2_c;
   end

   // temperature rounding and saturation
   always_comb begin
      tsum = m1_b5_ff + 30'sd8;
      tsh  = 26'(tsum >>> 4);
      if (tsh > 26'(T_MAX)) begin
         t_c = T_MAX;
      end else if (tsh < 26'(T_MIN)) begin
         t_c = T_MIN;
      end else begin
         t_c = tsh[15:0];
      end
   end

   // second-order terms
   always_comb begin
      x1b_c = 51'(m5_b2_ff >>> 11);
      x2b_c = 46'(m5_b1_ff >>> 16);
   end

   // b3 low word, exact modulo 2^34 before the final shift
   always_comb begin
      v_c = (m6_x3_ff[33:0] + {32'(cal.ac1), 2'b00}) << cal.oss;
      v_c = v_c + 34'd2;
   end

   // wrapped products
   always_comb begin
      scale_c = PRESS_SCALE >> cal.oss;
      b4w_c   = m7_x3p_ff * cal.ac4;
      b7w_c   = m8_b7a_ff * scale_c;
   end

   // pressure division operands
   always_comb begin
      ptag.t     = t_ff[9];
      ptag.err   = err_ff[8] | (m9_b4_ff == '0);
      ptag.big   = m9_b7_ff[31];
      ptag.spare = '0;
      dout.vld   = vld_ff[8];
      dout.num   = m9_b7_ff[31] ? m9_b7_ff : {m9_b7_ff[30:0], 1'b0};
      dout.den   = {1'b0, m9_b4_ff};
      dout.tag   = ptag;
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= din.vld;
         for (int k = 1; k < 9; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (en) begin
         err_ff[0] <= ttag.err;
         for (int k = 1; k < 9; k++) err_ff[k] <= err_ff[k-1];
         up_ff[1] <= ttag.up;
         for (int k = 2; k < 8; k++) up_ff[k] <= up_ff[k-1];
         t_ff[2] <= t_c;
         for (int k = 3; k < 10; k++) t_ff[k] <= t_ff[k-1];
         m1_b5_ff  <= b5_c;
         m2_b6_ff  <= m1_b5_ff - B6_OFFSET;
         m3_sq_ff  <= m2_b6_ff * m2_b6_ff;
         m3_a2_ff  <= m2_b6_ff * cal.ac2;
         m3_a3_ff  <= m2_b6_ff * cal.ac3;
         m4_sq_ff  <= 46'(m3_sq_ff >>> 12);
         m4_x2_ff  <= 34'(m3_a2_ff >>> 11);
         m4_x1_ff  <= 32'(m3_a3_ff >>> 13);
         m5_b2_ff  <= m4_sq_ff * cal.b2;
         m5_b1_ff  <= m4_sq_ff * cal.b1;
         m5_x2_ff  <= m4_x2_ff;
         m5_x1_ff  <= m4_x1_ff;
         m6_x3_ff  <= x1b_c + m5_x2_ff;
         m6_x3b_ff <= m5_x1_ff + x2b_c + 47'sd2;
         m7_b3_ff  <= v_c[33:2];
         m7_x3p_ff <= m6_x3b_ff[33:2] + B4_BIAS;
         m8_b7a_ff <= {13'b0, up_ff[7]} - m7_b3_ff;
         m8_b4p_ff <= b4w_c[31:0];
         m9_b7_ff  <= b7w_c[31:0];
         m9_b4_ff  <= m8_b4p_ff[31:15];
      end
   end

endmodule

// ===== design/bpc_back.sv =====
// bpc_back: pressure correction polynomial, saturation and the result
// register; uses bpc_pkg
`timescale 1ns / 1ps

module bpc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  bpc_pkg::div_type din,
   output logic             rsp_vld,
   output bpc_pkg::rsp_type rsp
);
   import bpc_pkg::*;

   logic               vld_ff [3];
   logic               rsp_vld_ff;
   logic               err_ff [3];
   logic signed [15:0] t_ff [3];
   logic [32:0]        b1_p_ff, b2_p_ff, b3_p_ff;
   logic [49:0]        b2_sq_ff;
   logic signed [47:0] b2_m_ff;
   logic [61:0]        b3_m1_ff;
   logic signed [31:0] b3_x2_ff;
   rsp_type            rsp_ff;

   ptag_type           ptag;
   logic [32:0]        p_c;
   logic signed [47:0] s_c, pn_c;
   rsp_type            rsp_in;

   // undo the pre-scaling of large dividends
   always_comb begin
      ptag = ptag_type'(din.tag);
      p_c  = ptag.big ? {din.num, 1'b0} : {1'b0, din.num};
   end

   // final correction and saturation
   always_comb begin
      s_c  = $signed({2'b0, b3_m1_ff[61:16]}) + 48'(b3_x2_ff) + P_BIAS;
      pn_c = $signed({15'b0, b3_p_ff}) + (s_c >>> 4);
      rsp_in.temp_tenths = t_ff[2];
      rsp_in.div_error   = err_ff[2];
      if (pn_c < 48'sd0) begin
         rsp_in.pressure_pa = '0;
      end else if (pn_c > $signed({28'b0, P_MAX})) begin
         rsp_in.pressure_pa = P_MAX;
      end else begin
         rsp_in.pressure_pa = pn_c[19:0];
      end
      if (err_ff[2]) begin
         rsp_in.temp_tenths = '0;
         rsp_in.pressure_pa = '0;
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) vld_ff[k] <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= din.vld;
         vld_ff[1] <= vld_ff[0];
         vld_ff[2] <= vld_ff[1];
         rsp_vld_ff <= vld_ff[2];
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (en) begin
         err_ff[0] <= ptag.err;
         t_ff[0]   <= ptag.t;
         for (int k = 1; k < 3; k++) begin
            err_ff[k] <= err_ff[k-1];
            t_ff[k]   <= t_ff[k-1];
         end
         b1_p_ff  <= p_c;
         b2_sq_ff <= b1_p_ff[32:8] * b1_p_ff[32:8];
         b2_m_ff  <= $signed({1'b0, b1_p_ff}) * P_LIN;
         b2_p_ff  <= b1_p_ff;
         b3_m1_ff <= b2_sq_ff * P_QUAD;
         b3_x2_ff <= 32'(b2_m_ff >>> 16);
         b3_p_ff  <= b2_p_ff;
         rsp_ff   <= rsp_in;
      end
   end

   assign rsp_vld = rsp_vld_ff;
   assign rsp     = rsp_ff;

endmodule

// ===== design/barometric_pressure_compensation_top.sv =====
// barometric_pressure_compensation_top: calibration registers and the
// compensation pipeline; uses bpc_pkg, bpc_front, bpc_div, bpc_mid, bpc_back
`timescale 1ns / 1ps

// Compensates one raw temperature / raw pressure pair per transaction and
// returns temperature in 0.1 degC, pressure in Pa and a divide error flag.
// The pipeline accepts one transaction every cycle unless stalled and has
// 4 front-end stages, 32 stages of the temperature divider, 9 coefficient
// stages, 32 stages of the pressure divider and 4 back-end stages
// including the result register. Both dividers retire one quotient bit per
// stage. A stall on the result channel holds the whole pipeline, and
// req_stall follows it. The user must write calibration through the csr port
// only while no transaction is in flight; the block itself does not enforce this.

module barometric_pressure_compensation_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  bpc_pkg::req_type                   req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output bpc_pkg::rsp_type                   rsp_payload,
   input  logic                               csr_wen,
   input  logic [bpc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bpc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import bpc_pkg::*;

   logic [31:0] pair_a_ff, pair_b_ff, pair_c_ff, pair_d_ff, pair_e_ff;
   logic [1:0]  oss_ff;
   cal_type     cal;
   logic        en;
   div_type     tdiv_in, tdiv_out, pdiv_in, pdiv_out;

   // calibration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pair_a_ff <= PAIR_A_RESET;
         pair_b_ff <= PAIR_B_RESET;
         pair_c_ff <= PAIR_C_RESET;
         pair_d_ff <= PAIR_D_RESET;
         pair_e_ff <= PAIR_E_RESET;
         oss_ff    <= OSS_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_PAIR_A: pair_a_ff <= csr_wdata;
            CSR_PAIR_B: pair_b_ff <= csr_wdata;
            CSR_PAIR_C: pair_c_ff <= csr_wdata;
            CSR_PAIR_D: pair_d_ff <= csr_wdata;
            CSR_PAIR_E: pair_e_ff <= csr_wdata;
            CSR_OSS:    oss_ff    <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // coefficient unpacking
   always_comb begin
      cal.ac1 = pair_a_ff[31:16];
      cal.ac2 = pair_a_ff[15:0];
      cal.ac3 = pair_b_ff[31:16];
      cal.ac4 = pair_b_ff[15:0];
      cal.ac5 = pair_c_ff[31:16];
      cal.ac6 = pair_c_ff[15:0];
      cal.b1  = pair_d_ff[31:16];
      cal.b2  = pair_d_ff[15:0];
      cal.mc  = pair_e_ff[31:16];
      cal.md  = pair_e_ff[15:0];
      cal.oss = oss_ff;
   end

   // pipeline advances unless a finished result is held
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   bpc_front u_front (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .req_vld (req_valid),
      .req     (req_payload),
      .cal     (cal),
      .dout    (tdiv_in)
   );

   bpc_div u_tdiv (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .din   (tdiv_in),
      .dout  (tdiv_out)
   );

   bpc_mid u_mid (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .din   (tdiv_out),
      .cal   (cal),
      .dout  (pdiv_in)
   );

   bpc_div u_pdiv (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .din   (pdiv_in),
      .dout  (pdiv_out)
   );

   bpc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .din     (pdiv_out),
      .rsp_vld (rsp_valid),
      .rsp     (rsp_payload)
   );

endmodule

// ===== design/bpc_checker.sv =====
// bpc_checker: port-level assertions for the compensation block and the
// bind that attaches them; uses bpc_pkg
`timescale 1ns / 1ps

module bpc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input bpc_pkg::rsp_type               rsp_payload
);

   // a held result stays and keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("held result changed");

   // an error transaction carries zero results
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.div_error |->
         rsp_payload.temp_tenths == '0 && rsp_payload.pressure_pa == '0)
      else $error("error result not zero");

   // input is held back only by a blocked result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a blocked result");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind barometric_pressure_compensation_top bpc_checker u_bpc_checker (.*);
